FILE: hw/rtl/sptk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sptk_pkg
// Shared constants and types for the sorted pair key table.
// ----------------------------------------------------------------------------
package sptk_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 64;
    localparam int ID_W        = 32;
    localparam int SLOT_W      = 6;
    localparam int ECOUNT_W    = 7;
    localparam int OUTCOME_W   = 3;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_FOUND     = 3'd0,
        OUT_INSERTED  = 3'd1,
        OUT_NOT_FOUND = 3'd2,
        OUT_INVALID   = 3'd3,
        OUT_FULL      = 3'd4
    } outcome_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [KEY_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

FILE: hw/rtl/sptk_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sptk_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sptk_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/sptk_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sptk_engine
// Binary search, shift-up insert and result sequencing over the key RAM.
// ----------------------------------------------------------------------------
module sptk_engine (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         mode,
    input  logic [sptk_pkg::ID_W-1:0]    first_id,
    input  logic [sptk_pkg::ID_W-1:0]    second_id,
    output logic                         busy,
    output logic                         done,
    output logic [sptk_pkg::OUTCOME_W-1:0] outcome,
    output logic [sptk_pkg::SLOT_W-1:0]  slot,
    output logic [sptk_pkg::ECOUNT_W-1:0] entry_count,
    output sptk_pkg::mem_req_t           mem_req,
    input  logic [sptk_pkg::KEY_W-1:0]   mem_rdata
);
    import sptk_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_PROBE  = 5'b00010,
        ST_CMP    = 5'b00100,
        ST_SHIFT  = 5'b01000,
        ST_INSERT = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              done_reg, done_next;

    logic [KEY_W-1:0]  key_reg, key_next;
    logic              mode_reg, mode_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [ADDR_W-1:0] mid_reg, mid_next;
    logic              found_reg, found_next;
    logic [ADDR_W-1:0] cur_reg, cur_next;
    logic [ADDR_W-1:0] last_reg, last_next;
    logic              pend_reg, pend_next;
    logic              more_reg, more_next;
    outcome_t          outcome_reg, outcome_next;
    logic [ADDR_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  ecount_reg, ecount_next;

    logic [CNT_W:0]    mid_sum;
    logic [ADDR_W-1:0] mid_addr;
    logic [ADDR_W-1:0] pos;
    logic              id_bad;

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_addr = mid_sum[ADDR_W:1];
    assign pos      = lo_reg[ADDR_W-1:0];
    assign id_bad   = (key_reg[KEY_W-1:ID_W] == '0) || (key_reg[ID_W-1:0] == '0);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        done_next    = 1'b0;
        key_next     = key_reg;
        mode_next    = mode_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        found_next   = found_reg;
        cur_next     = cur_reg;
        last_next    = last_reg;
        pend_next    = pend_reg;
        more_next    = more_reg;
        outcome_next = outcome_reg;
        slot_next    = slot_reg;
        ecount_next  = ecount_reg;
        mem_req      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    key_next   = {first_id, second_id};
                    mode_next  = mode;
                    lo_next    = '0;
                    hi_next    = count_reg;
                    found_next = 1'b0;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    mem_req.raddr = mid_addr;
                    mid_next      = mid_addr;
                    state_next    = ST_CMP;
                end
                else
                begin
                    slot_next   = '0;
                    ecount_next = count_reg;
                    if (found_reg)
                    begin
                        outcome_next = OUT_FOUND;
                        slot_next    = pos;
                        done_next    = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else if (!mode_reg)
                    begin
                        outcome_next = OUT_NOT_FOUND;
                        done_next    = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else if (id_bad)
                    begin
                        outcome_next = OUT_INVALID;
                        done_next    = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else if (count_reg >= CNT_W'(TABLE_DEPTH))
                    begin
                        outcome_next = OUT_FULL;
                        done_next    = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else if (count_reg == lo_reg)
                    begin
                        state_next = ST_INSERT;
                    end
                    else
                    begin
                        cur_next   = ADDR_W'(count_reg - CNT_W'(1));
                        pend_next  = 1'b0;
                        more_next  = 1'b1;
                        state_next = ST_SHIFT;
                    end
                end
            end
            ST_CMP:
            begin
                if (mem_rdata < key_reg)
                begin
                    lo_next = CNT_W'(mid_reg) + CNT_W'(1);
                end
                else
                begin
                    hi_next = CNT_W'(mid_reg);
                end
                if (mem_rdata == key_reg)
                begin
                    found_next = 1'b1;
                end
                state_next = ST_PROBE;
            end
            ST_SHIFT:
            begin
                // read entry i-1 while writing the previous read to i+1
                if (pend_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = last_reg + ADDR_W'(1);
                    mem_req.wdata = mem_rdata;
                end
                if (more_reg)
                begin
                    mem_req.raddr = cur_reg;
                    last_next     = cur_reg;
                    pend_next     = 1'b1;
                    more_next     = (cur_reg != pos);
                    cur_next      = cur_reg - ADDR_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = ST_INSERT;
                    end
                end
            end
            ST_INSERT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pos;
                mem_req.wdata = key_reg;
                count_next    = count_reg + CNT_W'(1);
                outcome_next  = OUT_INSERTED;
                slot_next     = pos;
                ecount_next   = count_reg + CNT_W'(1);
                done_next     = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            more_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            pend_reg  <= pend_next;
            more_reg  <= more_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        mode_reg    <= mode_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        cur_reg     <= cur_next;
        last_reg    <= last_next;
        outcome_reg <= outcome_next;
        slot_reg    <= slot_next;
        ecount_reg  <= ecount_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign outcome     = outcome_reg;
    assign slot        = SLOT_W'(slot_reg);
    assign entry_count = ECOUNT_W'(ecount_reg);

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result strobe outside idle");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("key count above table depth");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INSERT) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not bump key count");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_INSERT) |=> $stable(count_reg))
        else $error("key count changed outside insert");

    a_shift_above: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SHIFT) && mem_req.we) |-> (mem_req.waddr > pos))
        else $error("shift write at or below insert position");

endmodule

FILE: hw/rtl/sorted_pair_key_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_pair_key_table_core
// Sorted table of 64-bit keys {first_id, second_id} with lookup and insert.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; busy stays high until
// the result is out. The result appears for one cycle with done high and
// must be captured then, as there is no back pressure. Each binary-search
// probe of a lookup passes through the PROBE and CMP states, since every
// probe waits on the registered read of the key RAM. An insert then shifts
// the held keys from pos upward, one RAM entry moved per cycle, and skips
// the shift when the key goes after every held key; the new key is written
// at pos in the 64-entry table. The key RAM needs no clearing after reset.
// ----------------------------------------------------------------------------
module sorted_pair_key_table_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           mode,
    input  logic [sptk_pkg::ID_W-1:0]      first_id,
    input  logic [sptk_pkg::ID_W-1:0]      second_id,
    output logic                           done,
    output logic [sptk_pkg::OUTCOME_W-1:0] outcome,
    output logic [sptk_pkg::SLOT_W-1:0]    slot,
    output logic [sptk_pkg::ECOUNT_W-1:0]  entry_count
);
    import sptk_pkg::*;

    mem_req_t         mem_req;
    logic [KEY_W-1:0] mem_rdata;

    sptk_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .mode        (mode),
        .first_id    (first_id),
        .second_id   (second_id),
        .busy        (busy),
        .done        (done),
        .outcome     (outcome),
        .slot        (slot),
        .entry_count (entry_count),
        .mem_req     (mem_req),
        .mem_rdata   (mem_rdata)
    );

    sptk_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

endmodule
